[hdl/sps_pkg.sv]
package sps_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SETTLE  = 4'd1,
        PH_M_PULSE = 4'd2,
        PH_M_HIT   = 4'd3,
        PH_R_HIT   = 4'd4,
        PH_R_PULSE = 4'd5,
        PH_H_PULSE = 4'd6,
        PH_H_HIT   = 4'd7,
        PH_PAUSE   = 4'd8,
        PH_B_HIT   = 4'd9,
        PH_B_PULSE = 4'd10,
        PH_C_PULSE = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_HOME = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_HALF_PERIOD = 3'd0,
        CFG_PAUSE       = 3'd1,
        CFG_MICROSTEP   = 3'd2,
        CFG_BURST       = 3'd3,
        CFG_CLEARANCE   = 3'd4
    } cfg_idx_t;

    localparam int CFG_DATA_W = 24;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd1000;
    localparam logic [23:0] PAUSE_RST       = 24'd3000;
    localparam logic [2:0]  MICROSTEP_RST   = 3'd1;
    localparam logic [9:0]  BURST_RST       = 10'd100;
    localparam logic [11:0] CLEARANCE_RST   = 12'd500;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [23:0] pause_ticks;
        logic [2:0]  microstep_mode;
        logic [9:0]  backoff_burst_steps;
        logic [11:0] clearance_steps;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic        active_motor;
        logic [19:0] steps_left;
        logic [23:0] tick_count;
        logic [11:0] burst_count;
        logic        move_positive;
        logic [1:0]  dir_pins;
        logic [1:0]  step_pins;
        logic        enable_pin;
        logic [5:0]  microstep_pins;
        logic [3:0]  limit_flags;
    } seq_state_t;

    localparam seq_state_t SEQ_STATE_RST = '{
        phase:          PH_IDLE,
        active_motor:   1'b0,
        steps_left:     20'd0,
        tick_count:     24'd0,
        burst_count:    12'd0,
        move_positive:  1'b0,
        dir_pins:       2'b11,
        step_pins:      2'b00,
        enable_pin:     1'b0,
        microstep_pins: 6'd0,
        limit_flags:    4'd0
    };

    // MS3..MS1 pattern per microstep mode, sixteenth for unused codes
    function automatic logic [2:0] ms_pattern(input logic [2:0] mode);
        logic [2:0] pat;
        unique case (mode)
            3'd0:    pat = 3'b000;
            3'd1:    pat = 3'b001;
            3'd2:    pat = 3'b010;
            3'd3:    pat = 3'b011;
            default: pat = 3'b111;
        endcase
        return pat;
    endfunction

endpackage

[hdl/sps_step_core.sv]
module sps_step_core (
    input  sps_pkg::seq_state_t cur,
    input  sps_pkg::cfg_t       cfg,
    input  logic [1:0]          command,
    input  logic                motor_sel,
    input  logic signed [20:0]  step_count,
    input  logic                endstop_a_n,
    input  logic                endstop_b_n,
    output sps_pkg::seq_state_t nxt
);
    import sps_pkg::*;

    function automatic seq_state_t f_finish(input seq_state_t s);
        seq_state_t r;
        r = s;
        r.step_pins  = 2'b00;
        r.enable_pin = 1'b0;
        r.phase      = PH_IDLE;
        r.tick_count = '0;
        return r;
    endfunction

    function automatic seq_state_t f_wait(input seq_state_t s, input phase_t ph);
        seq_state_t r;
        r = s;
        r.phase      = ph;
        r.tick_count = '0;
        return r;
    endfunction

    function automatic seq_state_t f_pulse(input seq_state_t s, input phase_t ph,
                                           input logic [1:0] mb);
        seq_state_t r;
        r = f_wait(s, ph);
        r.step_pins = r.step_pins | mb;
        return r;
    endfunction

    function automatic seq_state_t f_move_next(input seq_state_t s, input logic [1:0] mb);
        seq_state_t r;
        r = s;
        if (s.steps_left == '0) begin
            r = f_finish(s);
        end else begin
            r.steps_left = s.steps_left - 20'd1;
            r = f_pulse(r, PH_M_PULSE, mb);
        end
        return r;
    endfunction

    function automatic seq_state_t f_retreat(input seq_state_t s, input logic pressed);
        seq_state_t r;
        r = s;
        if (pressed) begin
            r = f_wait(s, PH_R_HIT);
        end else begin
            r.limit_flags[{s.active_motor, s.move_positive}] = 1'b1;
            r = f_finish(r);
        end
        return r;
    endfunction

    function automatic seq_state_t f_home(input seq_state_t s, input logic pressed,
                                          input logic [1:0] mb);
        seq_state_t r;
        if (pressed) r = f_wait(s, PH_H_HIT);
        else         r = f_pulse(s, PH_H_PULSE, mb);
        return r;
    endfunction

    function automatic seq_state_t f_burst(input seq_state_t s, input logic [1:0] mb);
        seq_state_t r;
        r = s;
        if (s.burst_count == '0) begin
            r.enable_pin = 1'b0;
            r = f_wait(r, PH_PAUSE);
        end else begin
            r.burst_count = s.burst_count - 12'd1;
            r = f_pulse(r, PH_B_PULSE, mb);
        end
        return r;
    endfunction

    function automatic seq_state_t f_clear(input seq_state_t s, input logic [1:0] mb);
        seq_state_t r;
        r = s;
        if (s.burst_count == '0) begin
            r = f_finish(s);
        end else begin
            r.burst_count = s.burst_count - 12'd1;
            r = f_pulse(r, PH_C_PULSE, mb);
        end
        return r;
    endfunction

    logic        pressed;
    logic [1:0]  mb_cur;
    logic [1:0]  mb_sel;
    logic [15:0] half;
    logic [23:0] half_w;
    logic [23:0] period_w;
    logic [23:0] pause_w;
    logic [23:0] tick_inc;
    logic [20:0] neg_count;
    logic [2:0]  ms_bits;
    logic        pulse_phase;

    assign pressed  = !endstop_a_n || !endstop_b_n;
    assign mb_cur   = cur.active_motor ? 2'b10 : 2'b01;
    assign mb_sel   = motor_sel ? 2'b10 : 2'b01;
    assign half     = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
    assign half_w   = {8'd0, half};
    assign period_w = {7'd0, half, 1'b0};
    assign pause_w  = (cfg.pause_ticks == '0) ? 24'd1 : cfg.pause_ticks;
    assign tick_inc = cur.tick_count + 24'd1;
    assign neg_count = -step_count;
    assign ms_bits  = ms_pattern(cfg.microstep_mode);
    assign pulse_phase = (cur.phase == PH_M_PULSE) || (cur.phase == PH_R_PULSE) ||
                         (cur.phase == PH_H_PULSE) || (cur.phase == PH_B_PULSE) ||
                         (cur.phase == PH_C_PULSE);

    always_comb begin
        nxt = cur;
        if (cur.phase == PH_IDLE) begin
            if (command == CMD_MOVE || command == CMD_HOME) begin
                nxt.active_motor = motor_sel;
                if (motor_sel) nxt.microstep_pins = {ms_bits, cur.microstep_pins[2:0]};
                else           nxt.microstep_pins = {cur.microstep_pins[5:3], ms_bits};
                nxt.enable_pin = 1'b1;
                if (command == CMD_MOVE) begin
                    if (step_count[20]) begin
                        // magnitude of the most negative count saturates
                        nxt.steps_left    = neg_count[20] ? 20'hFFFFF : neg_count[19:0];
                        nxt.move_positive = 1'b0;
                        nxt.dir_pins      = cur.dir_pins | mb_sel;
                    end else begin
                        nxt.steps_left    = step_count[19:0];
                        nxt.move_positive = 1'b1;
                        nxt.dir_pins      = cur.dir_pins & ~mb_sel;
                    end
                    nxt = f_wait(nxt, PH_SETTLE);
                end else begin
                    nxt.dir_pins = cur.dir_pins | mb_sel;
                    nxt = f_home(nxt, pressed, mb_sel);
                end
            end
        end else begin
            nxt.tick_count = tick_inc;
            if (pulse_phase) begin
                if (tick_inc >= half_w) nxt.step_pins = nxt.step_pins & ~mb_cur;
                if (tick_inc >= period_w) begin
                    unique case (cur.phase)
                        PH_M_PULSE: begin
                            if (pressed) nxt = f_wait(nxt, PH_M_HIT);
                            else         nxt = f_move_next(nxt, mb_cur);
                        end
                        PH_R_PULSE: nxt = f_retreat(nxt, pressed);
                        PH_H_PULSE: nxt = f_home(nxt, pressed, mb_cur);
                        PH_B_PULSE: nxt = f_burst(nxt, mb_cur);
                        default:    nxt = f_clear(nxt, mb_cur);
                    endcase
                end
            end else if (cur.phase == PH_PAUSE) begin
                if (tick_inc >= pause_w) begin
                    nxt.enable_pin = 1'b1;
                    if (pressed) begin
                        nxt.burst_count = {2'b00, cfg.backoff_burst_steps};
                        nxt = f_wait(nxt, PH_B_HIT);
                    end else begin
                        nxt.burst_count = cfg.clearance_steps;
                        nxt = f_clear(nxt, mb_cur);
                    end
                end
            end else if (tick_inc >= half_w) begin
                unique case (cur.phase)
                    PH_SETTLE: nxt = f_move_next(nxt, mb_cur);
                    PH_M_HIT: begin
                        if (cur.move_positive) nxt.dir_pins = nxt.dir_pins | mb_cur;
                        else                   nxt.dir_pins = nxt.dir_pins & ~mb_cur;
                        nxt = f_retreat(nxt, pressed);
                    end
                    PH_R_HIT: nxt = f_pulse(nxt, PH_R_PULSE, mb_cur);
                    PH_H_HIT: begin
                        nxt.dir_pins   = nxt.dir_pins & ~mb_cur;
                        nxt.enable_pin = 1'b0;
                        nxt = f_wait(nxt, PH_PAUSE);
                    end
                    PH_B_HIT: nxt = f_burst(nxt, mb_cur);
                    default:  nxt = f_finish(nxt);
                endcase
            end
        end
    end

endmodule

[hdl/stepper_pulse_sequencer_homing.sv]
// path: an accepted input transaction passes the input register, then the sequencer
// state and result register, on its way to its result transaction
// throughput: one transaction per cycle while the result side is not stalled by m_ready
// reset: synchronous, active-low aresetn clears the sequencer to idle, dir pins
// high, step and enable low, limit flags clear, config registers to defaults
module stepper_pulse_sequencer_homing (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_command,
    input  logic                               s_motor_sel,
    input  logic signed [20:0]                 s_step_count,
    input  logic                               s_endstop_a_n,
    input  logic                               s_endstop_b_n,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_step_a,
    output logic                               m_step_b,
    output logic                               m_dir_a,
    output logic                               m_dir_b,
    output logic                               m_drive_enable,
    output logic [2:0]                         m_microstep_a,
    output logic [2:0]                         m_microstep_b,
    output logic                               m_busy_res,
    output logic                               m_at_min_a,
    output logic                               m_at_max_a,
    output logic                               m_at_min_b,
    output logic                               m_at_max_b
);
    import sps_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // input register stage
    logic               in_valid_reg;
    logic [1:0]         cmd_reg;
    logic               motor_sel_reg;
    logic signed [20:0] step_count_reg;
    logic               endstop_a_n_reg;
    logic               endstop_b_n_reg;

    // sequencer state and result register
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       m_valid_reg;

    logic       out_free;   // result register can take a new transaction
    logic       fire;       // registered input is processed this cycle
    logic       s_take;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // config writes land immediately; out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks   <= HALF_PERIOD_RST;
            cfg_reg.pause_ticks         <= PAUSE_RST;
            cfg_reg.microstep_mode      <= MICROSTEP_RST;
            cfg_reg.backoff_burst_steps <= BURST_RST;
            cfg_reg.clearance_steps     <= CLEARANCE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks   <= cfg_wdata[15:0];
                CFG_PAUSE:       cfg_reg.pause_ticks         <= cfg_wdata[23:0];
                CFG_MICROSTEP:   cfg_reg.microstep_mode      <= cfg_wdata[2:0];
                CFG_BURST:       cfg_reg.backoff_burst_steps <= cfg_wdata[9:0];
                CFG_CLEARANCE:   cfg_reg.clearance_steps     <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // input stage: refills in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            cmd_reg         <= s_command;
            motor_sel_reg   <= s_motor_sel;
            step_count_reg  <= s_step_count;
            endstop_a_n_reg <= s_endstop_a_n;
            endstop_b_n_reg <= s_endstop_b_n;
        end
    end

    // one clock tick of the sequencer per transaction
    sps_step_core u_core (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .command     (cmd_reg),
        .motor_sel   (motor_sel_reg),
        .step_count  (step_count_reg),
        .endstop_a_n (endstop_a_n_reg),
        .endstop_b_n (endstop_b_n_reg),
        .nxt         (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_STATE_RST;
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            state_reg   <= state_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, snapshot of the pins after the tick
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_step_a       <= state_next.step_pins[0];
            m_step_b       <= state_next.step_pins[1];
            m_dir_a        <= state_next.dir_pins[0];
            m_dir_b        <= state_next.dir_pins[1];
            m_drive_enable <= state_next.enable_pin;
            m_microstep_a  <= state_next.microstep_pins[2:0];
            m_microstep_b  <= state_next.microstep_pins[5:3];
            m_busy_res     <= (state_next.phase != PH_IDLE);
            m_at_min_a     <= state_next.limit_flags[0];
            m_at_max_a     <= state_next.limit_flags[1];
            m_at_min_b     <= state_next.limit_flags[2];
            m_at_max_b     <= state_next.limit_flags[3];
        end
    end

`ifndef SYNTHESIS
    // only the active motor is ever pulsed
    a_one_step_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.step_pins != 2'b11)
        else $error("both step pins high");

    // an idle sequencer leaves step and enable low
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_IDLE) |->
        (state_reg.step_pins == 2'b00 && !state_reg.enable_pin))
        else $error("idle with step or enable active");

    // limit flags are sticky
    a_flags_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> ((state_reg.limit_flags & $past(state_reg.limit_flags)) ==
                  $past(state_reg.limit_flags)))
        else $error("limit flag cleared");

    // input backpressure only when both stages are full and the output stalls
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without cause");
`endif

endmodule

[tb/tb_stepper_pulse_sequencer_homing.sv]
`timescale 1ns / 100ps

module tb_stepper_pulse_sequencer_homing;
    import sps_pkg::*;

    // block latency from an input transaction to its result transaction
    localparam int PIPE_LATENCY = 2;
    // command code that the block treats as a plain tick
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // pin levels carried by one result transaction, in port order
    typedef struct packed {
        logic       step_a;
        logic       step_b;
        logic       dir_a;
        logic       dir_b;
        logic       drive_enable;
        logic [2:0] microstep_a;
        logic [2:0] microstep_b;
        logic       busy;
        logic       at_min_a;
        logic       at_max_a;
        logic       at_min_b;
        logic       at_max_b;
    } pin_state_t;

    // mirror of the sequencer: own copy of registers and state, plus the
    // pin states still owed by the block
    class sequencer_mirror;
        bit [15:0]  half_cfg;
        bit [23:0]  pause_cfg;
        bit [2:0]   ms_cfg;
        bit [9:0]   burst_cfg;
        bit [11:0]  clear_cfg;

        phase_t     ph;
        bit         motor;
        bit [19:0]  steps_left;
        bit [23:0]  ticks;
        bit [11:0]  pulses_left;
        bit         positive;
        bit [1:0]   dir_p;
        bit [1:0]   step_p;
        bit         en;
        bit [5:0]   ms_p;
        bit [3:0]   flags;

        pin_state_t pins_due[$];
        int         errors;

        function new();
            half_cfg    = HALF_PERIOD_RST;
            pause_cfg   = PAUSE_RST;
            ms_cfg      = MICROSTEP_RST;
            burst_cfg   = BURST_RST;
            clear_cfg   = CLEARANCE_RST;
            ph          = PH_IDLE;
            motor       = 1'b0;
            steps_left  = '0;
            ticks       = '0;
            pulses_left = '0;
            positive    = 1'b0;
            dir_p       = 2'b11;
            step_p      = 2'b00;
            en          = 1'b0;
            ms_p        = '0;
            flags       = '0;
            errors      = 0;
        endfunction

        function void set_cfg(cfg_idx_t idx, logic [23:0] val);
            case (idx)
                CFG_HALF_PERIOD: half_cfg  = val[15:0];
                CFG_PAUSE:       pause_cfg = val;
                CFG_MICROSTEP:   ms_cfg    = val[2:0];
                CFG_BURST:       burst_cfg = val[9:0];
                CFG_CLEARANCE:   clear_cfg = val[11:0];
                default: ;
            endcase
        endfunction

        function bit is_busy();
            return ph != PH_IDLE;
        endfunction

        function int pending();
            return pins_due.size();
        endfunction

        function int unsigned half_len();
            return (half_cfg == 0) ? 1 : half_cfg;
        endfunction

        function bit [1:0] motor_mask();
            return motor ? 2'b10 : 2'b01;
        endfunction

        function bit [2:0] ms_code(bit [2:0] mode);
            return (mode <= 3) ? mode : 3'b111;
        endfunction

        function void go_idle();
            step_p = 2'b00;
            en     = 1'b0;
            ph     = PH_IDLE;
            ticks  = '0;
        endfunction

        function void start_wait(phase_t p);
            ph    = p;
            ticks = '0;
        endfunction

        function void start_pulse(phase_t p);
            ph     = p;
            ticks  = '0;
            step_p = step_p | motor_mask();
        endfunction

        function void set_dir(bit high);
            if (high) dir_p = dir_p | motor_mask();
            else dir_p = dir_p & ~motor_mask();
        endfunction

        function void next_move_step();
            if (steps_left == 0) begin
                go_idle();
                return;
            end
            steps_left--;
            start_pulse(PH_M_PULSE);
        endfunction

        function void retreat_check(bit pressed);
            if (pressed) begin
                start_wait(PH_R_HIT);
                return;
            end
            flags[{motor, positive}] = 1'b1;
            go_idle();
        endfunction

        function void home_check(bit pressed);
            if (pressed) start_wait(PH_H_HIT);
            else start_pulse(PH_H_PULSE);
        endfunction

        function void next_burst();
            if (pulses_left == 0) begin
                en = 1'b0;
                start_wait(PH_PAUSE);
                return;
            end
            pulses_left--;
            start_pulse(PH_B_PULSE);
        endfunction

        function void next_clear();
            if (pulses_left == 0) begin
                go_idle();
                return;
            end
            pulses_left--;
            start_pulse(PH_C_PULSE);
        endfunction

        function void advance(bit pressed);
            int unsigned half;
            half  = half_len();
            ticks = ticks + 1'b1;
            case (ph)
                PH_M_PULSE, PH_R_PULSE, PH_H_PULSE, PH_B_PULSE, PH_C_PULSE: begin
                    if (ticks >= half) step_p = step_p & ~motor_mask();
                    if (ticks < 2 * half) return;
                    case (ph)
                        PH_M_PULSE: begin
                            if (pressed) start_wait(PH_M_HIT);
                            else next_move_step();
                        end
                        PH_R_PULSE: retreat_check(pressed);
                        PH_H_PULSE: home_check(pressed);
                        PH_B_PULSE: next_burst();
                        default:    next_clear();
                    endcase
                    return;
                end
                PH_PAUSE: begin
                    if (ticks < ((pause_cfg == 0) ? 24'd1 : pause_cfg)) return;
                    en = 1'b1;
                    if (pressed) begin
                        pulses_left = 12'(burst_cfg);
                        start_wait(PH_B_HIT);
                    end else begin
                        pulses_left = clear_cfg;
                        next_clear();
                    end
                    return;
                end
                default: ;
            endcase
            if (ticks < half) return;
            case (ph)
                PH_SETTLE: next_move_step();
                PH_M_HIT: begin
                    set_dir(positive);
                    retreat_check(pressed);
                end
                PH_R_HIT: start_pulse(PH_R_PULSE);
                PH_H_HIT: begin
                    set_dir(1'b0);
                    en = 1'b0;
                    start_wait(PH_PAUSE);
                end
                PH_B_HIT: next_burst();
                default:  go_idle();
            endcase
        endfunction

        // one accepted input transaction: step the mirror, queue the pins
        function void apply_item(logic [1:0] cmd, logic motor_sel, logic [20:0] count,
                                 logic ea, logic eb);
            bit         pressed;
            bit [21:0]  mag;
            pin_state_t want;
            pressed = !ea || !eb;
            if (ph == PH_IDLE && (cmd == CMD_MOVE || cmd == CMD_HOME)) begin
                motor = motor_sel;
                if (motor) ms_p[5:3] = ms_code(ms_cfg);
                else ms_p[2:0] = ms_code(ms_cfg);
                en = 1'b1;
                if (cmd == CMD_MOVE) begin
                    if (count[20]) begin
                        mag = 22'h200000 - {1'b0, count};
                        if (mag > 22'h0FFFFF) mag = 22'h0FFFFF;
                        positive = 1'b0;
                    end else begin
                        mag = {1'b0, count};
                        positive = 1'b1;
                    end
                    steps_left = mag[19:0];
                    set_dir(!positive);
                    start_wait(PH_SETTLE);
                end else begin
                    set_dir(1'b1);
                    home_check(pressed);
                end
            end else if (ph != PH_IDLE) begin
                advance(pressed);
            end
            want.step_a       = step_p[0];
            want.step_b       = step_p[1];
            want.dir_a        = dir_p[0];
            want.dir_b        = dir_p[1];
            want.drive_enable = en;
            want.microstep_a  = ms_p[2:0];
            want.microstep_b  = ms_p[5:3];
            want.busy         = (ph != PH_IDLE);
            want.at_min_a     = flags[0];
            want.at_max_a     = flags[1];
            want.at_min_b     = flags[2];
            want.at_max_b     = flags[3];
            pins_due.push_back(want);
        endfunction

        function void check_field(string name, logic [2:0] want, logic [2:0] got);
            if (want !== got) begin
                $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void compare_pins(pin_state_t got);
            pin_state_t want;
            if (pins_due.size() == 0) begin
                $display("%0t unexpected result transaction, expected none, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = pins_due.pop_front();
            check_field("step_a",       3'(want.step_a),       3'(got.step_a));
            check_field("step_b",       3'(want.step_b),       3'(got.step_b));
            check_field("dir_a",        3'(want.dir_a),        3'(got.dir_a));
            check_field("dir_b",        3'(want.dir_b),        3'(got.dir_b));
            check_field("drive_enable", 3'(want.drive_enable), 3'(got.drive_enable));
            check_field("microstep_a",  want.microstep_a,      got.microstep_a);
            check_field("microstep_b",  want.microstep_b,      got.microstep_b);
            check_field("busy_res",     3'(want.busy),         3'(got.busy));
            check_field("at_min_a",     3'(want.at_min_a),     3'(got.at_min_a));
            check_field("at_max_a",     3'(want.at_max_a),     3'(got.at_max_a));
            check_field("at_min_b",     3'(want.at_min_b),     3'(got.at_min_b));
            check_field("at_max_b",     3'(want.at_max_b),     3'(got.at_max_b));
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [2:0]            cfg_index     = CFG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic [1:0]            s_command     = CMD_TICK;
    logic                  s_motor_sel   = 1'b0;
    logic signed [20:0]    s_step_count  = '0;
    logic                  s_endstop_a_n = 1'b1;
    logic                  s_endstop_b_n = 1'b1;
    logic                  m_ready       = 1'b0;

    logic       s_ready;
    logic       m_valid;
    logic       m_step_a, m_step_b, m_dir_a, m_dir_b, m_drive_enable;
    logic [2:0] m_microstep_a, m_microstep_b;
    logic       m_busy_res, m_at_min_a, m_at_max_a, m_at_min_b, m_at_max_b;

    sequencer_mirror sb = new();

    // idling on both sides is switched off now and then for stretches
    bit idle_on    = 1'b1;
    int ready_left = 0;

    // endstop pattern of the random part: runs of pressed and released
    bit es_pressed = 1'b0;
    int es_run     = 0;
    int es_which   = 0;

    stepper_pulse_sequencer_homing uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_motor_sel    (s_motor_sel),
        .s_step_count   (s_step_count),
        .s_endstop_a_n  (s_endstop_a_n),
        .s_endstop_b_n  (s_endstop_b_n),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_step_a       (m_step_a),
        .m_step_b       (m_step_b),
        .m_dir_a        (m_dir_a),
        .m_dir_b        (m_dir_b),
        .m_drive_enable (m_drive_enable),
        .m_microstep_a  (m_microstep_a),
        .m_microstep_b  (m_microstep_b),
        .m_busy_res     (m_busy_res),
        .m_at_min_a     (m_at_min_a),
        .m_at_max_a     (m_at_max_a),
        .m_at_min_b     (m_at_min_b),
        .m_at_max_b     (m_at_max_b)
    );

    always #5 aclk = ~aclk;

    // mostly short gaps, a few long ones, none while idling is off
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // move length: mostly short, some medium, a few full range and extremes
    function automatic logic [20:0] pick_count();
        int r;
        int mag;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            mag = $urandom_range(0, 6);
        end else if (r < 85) begin
            mag = $urandom_range(0, 40);
        end else if (r < 95) begin
            return 21'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0:       return 21'h0FFFFF;
                1:       return 21'h100000;
                2:       return 21'h100001;
                default: return 21'h1FFFFF;
            endcase
        end
        return ($urandom_range(0, 1) != 0) ? 21'(-mag) : 21'(mag);
    endfunction

    // result side: random stalls on m_ready, held for a random run
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left--;
        end else if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            case ($urandom_range(0, 19))
                0:       ready_left = $urandom_range(9, 30);
                1, 2, 3: ready_left = $urandom_range(3, 8);
                default: ready_left = $urandom_range(0, 2);
            endcase
        end else begin
            m_ready <= 1'b1;
            ready_left = $urandom_range(0, 20);
        end
    end

    // every result transaction is checked against the oldest pin state owed
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.compare_pins({m_step_a, m_step_b, m_dir_a, m_dir_b, m_drive_enable,
                             m_microstep_a, m_microstep_b, m_busy_res,
                             m_at_min_a, m_at_max_a, m_at_min_b, m_at_max_b});
        end
    end

    // present one transaction and hold it until accepted; the mirror is
    // stepped here so the next choice sees the updated state
    task automatic issue(input logic [1:0] cmd, input logic motor, input logic [20:0] count,
                         input logic ea, input logic eb);
        int gap;
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_motor_sel   <= motor;
        s_step_count  <= count;
        s_endstop_a_n <= ea;
        s_endstop_b_n <= eb;
        do @(posedge aclk); while (!s_ready);
        sb.apply_item(cmd, motor, count, ea, eb);
        if ($urandom_range(0, 49) == 0) idle_on = !idle_on;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // plain ticks with the ignored fields randomized
    task automatic tick_n(input int n, input logic ea, input logic eb);
        repeat (n) issue(CMD_TICK, 1'($urandom), 21'($urandom), ea, eb);
    endtask

    // tick until the running sequence ends: switches released, except
    // pressed while homing seeks the endstop
    task automatic drain_seq(input int cap);
        int   n;
        logic press;
        logic sel;
        n = 0;
        while (sb.is_busy() && n < cap) begin
            press = (sb.ph == PH_H_PULSE);
            sel   = 1'($urandom);
            issue(CMD_TICK, 1'($urandom), 21'($urandom), !(press && sel), !(press && !sel));
            n++;
        end
    endtask

    // stop sending and wait for every owed result plus the pipeline depth
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    // write all five registers back to back once the block is quiet
    task automatic load_cfg(input logic [23:0] hp, input logic [23:0] pa,
                            input logic [23:0] ms, input logic [23:0] bu,
                            input logic [23:0] cl);
        cfg_idx_t    order[5] = '{CFG_HALF_PERIOD, CFG_PAUSE, CFG_MICROSTEP,
                                  CFG_BURST, CFG_CLEARANCE};
        logic [23:0] vals[5];
        vals = '{hp, pa, ms, bu, cl};
        settle();
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_cfg(order[i], vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // random part: mostly full move and homing sequences with endstop runs,
    // plus commands while busy, the unused code and stray ticks
    task automatic run_random(input int count);
        int          r;
        logic        ea;
        logic        eb;
        logic [20:0] junk;
        for (int k = 0; k < count; k++) begin
            if (es_run == 0) begin
                es_pressed = !es_pressed;
                es_run     = es_pressed ? $urandom_range(1, 12) : $urandom_range(1, 30);
                es_which   = $urandom_range(0, 2);
            end
            es_run--;
            ea = !(es_pressed && es_which != 1);
            eb = !(es_pressed && es_which != 0);
            // occasional glitch on one switch
            if ($urandom_range(0, 99) < 3) ea = !ea;
            junk = 21'($urandom);
            r    = $urandom_range(0, 99);
            if (!sb.is_busy()) begin
                if (r < 55) issue(CMD_MOVE, 1'($urandom), pick_count(), ea, eb);
                else if (r < 85) issue(CMD_HOME, 1'($urandom), junk, ea, eb);
                else if (r < 93) issue(CMD_TICK, 1'($urandom), junk, ea, eb);
                else issue(CMD_UNUSED, 1'($urandom), junk, ea, eb);
            end else begin
                if (r < 80) issue(CMD_TICK, 1'($urandom), junk, ea, eb);
                else if (r < 85) issue(CMD_MOVE, 1'($urandom), pick_count(), ea, eb);
                else if (r < 90) issue(CMD_HOME, 1'($urandom), junk, ea, eb);
                else if (r < 95) issue(CMD_UNUSED, 1'($urandom), junk, ea, eb);
                else issue(CMD_TICK, 1'($urandom), pick_count(), ea, eb);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pins straight out of reset, default registers
        tick_n(3, 1'b1, 1'b1);

        // directed: shortest timing, zero pause, full step, zero clearance
        load_cfg(24'd1, 24'd0, 24'd0, 24'd1, 24'd0);
        issue(CMD_MOVE, 1'b0, 21'sd2, 1'b1, 1'b1);
        drain_seq(100);
        issue(CMD_MOVE, 1'b1, -21'sd1, 1'b1, 1'b1);
        drain_seq(100);
        // zero count: enable for one half period only
        issue(CMD_MOVE, 1'b0, 21'sd0, 1'b1, 1'b1);
        drain_seq(100);
        issue(CMD_UNUSED, 1'b1, 21'($urandom), 1'b1, 1'b1);
        // most negative count saturates, stopped by switch a, sets min of b
        issue(CMD_MOVE, 1'b1, 21'h100000, 1'b1, 1'b1);
        tick_n(3, 1'b1, 1'b1);
        tick_n(3, 1'b0, 1'b1);
        drain_seq(100);
        // largest positive count, stopped by switch b, sets max of a
        issue(CMD_MOVE, 1'b0, 21'h0FFFFF, 1'b1, 1'b1);
        tick_n(3, 1'b1, 1'b1);
        tick_n(3, 1'b1, 1'b0);
        drain_seq(100);
        // commands while busy are ignored
        issue(CMD_MOVE, 1'b0, 21'sd5, 1'b1, 1'b1);
        issue(CMD_MOVE, 1'b1, -21'sd7, 1'b1, 1'b1);
        issue(CMD_HOME, 1'b1, 21'($urandom), 1'b1, 1'b1);
        drain_seq(100);
        // homing with the switch already pressed on the command itself
        issue(CMD_HOME, 1'b1, 21'($urandom), 1'b0, 1'b0);
        drain_seq(100);
        // homing that seeks, hits and clears at once
        issue(CMD_HOME, 1'b0, 21'($urandom), 1'b1, 1'b1);
        tick_n(4, 1'b1, 1'b1);
        drain_seq(100);
        // homing that stays pressed through several back-off bursts
        issue(CMD_HOME, 1'b1, 21'($urandom), 1'b1, 1'b0);
        tick_n(8, 1'b1, 1'b0);
        drain_seq(100);

        // random phases over several register settings
        load_cfg(24'd2, 24'd3, 24'd4, 24'd2, 24'd3);
        run_random(140);
        drain_seq(150);

        // zero half period and zero burst, microstep code above sixteenth
        load_cfg(24'd0, 24'd1, 24'd7, 24'd0, 24'd1);
        run_random(70);
        drain_seq(150);

        // top of every range but the microstep code; the running sequence carries into the next phase
        load_cfg(24'd65535, 24'hFFFFFF, 24'd5, 24'd1023, 24'd4095);
        run_random(30);

        load_cfg(24'd1, 24'd2, 24'd2, 24'd1023, 24'd4095);
        run_random(20);
        drain_seq(150);

        load_cfg(24'd3, 24'd5, 24'd3, 24'd3, 24'd2);
        run_random(140);
        drain_seq(150);

        settle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_stepper_pulse_sequencer_homing: done, clean");
        end else begin
            $display("tb_stepper_pulse_sequencer_homing: done, errors");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("tb_stepper_pulse_sequencer_homing: done, errors");
        $finish;
    end

endmodule
